// ----- rtl/sgdlr_pkg.sv -----
// Shared types, constants and helpers of the SGD linear regression learner.
// No dependencies.
`timescale 1ns / 1ps
package sgdlr_pkg;

  localparam int MaxFeatures = 16;
  localparam int FracBits    = 16;
  localparam int LrFrac      = 16;
  localparam int KW          = $clog2(MaxFeatures + 1);
  localparam int BW          = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;
  localparam int QDepth      = 2;

  localparam logic [1:0] CfgLearnRate = 2'd0;
  localparam logic [1:0] CfgFeatCount = 2'd1;
  localparam logic [1:0] CfgLearnEn   = 2'd2;

  typedef enum logic [1:0] {
    OpFeature = 2'd0,
    OpTarget  = 2'd1,
    OpClear   = 2'd2,
    OpRead    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [23:0] value;
    logic [4:0]         index;
  } item_t;

  typedef struct packed {
    logic [15:0] step_size;
    logic [4:0]  feature_count;
    logic        learn_enable;
  } cfg_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/sgdlr_if.sv -----
// Channel interfaces of the learner: input beat and result beat.
// Depends on nothing.
`timescale 1ns / 1ps
interface sgdlr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [23:0] sample_value;
  logic [4:0]         weight_index;
  modport source (output valid, opcode, sample_value, weight_index, input ready);
  modport sink   (input valid, opcode, sample_value, weight_index, output ready);
endinterface

interface sgdlr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prediction;
  logic signed [31:0] residual;
  logic [47:0]        squared_error_sum;
  logic [31:0]        sample_count;
  logic signed [31:0] weight_value;
  logic               saturated;
  modport source (output valid, prediction, residual, squared_error_sum, sample_count,
                  weight_value, saturated, input ready);
  modport sink   (input valid, prediction, residual, squared_error_sum, sample_count,
                  weight_value, saturated, output ready);
endinterface

// ----- rtl/sgd_linear_regression_learner.sv -----
// Online SGD linear regression learner, fixed point, with a queued front end.
// Depends on sgdlr_pkg, sgdlr_if, sgdlr_front and sgdlr_back.
// Feature and clear beats finish in the idle state, a read beat in the emit
// state. A target beat is paced by the single shared multiplier, which walks
// the active feature weights for the dot product and again for the update
// (learning on). A two-entry queue takes beats while one executes.
`timescale 1ns / 1ps
module sgd_linear_regression_learner (
  input  logic        clk_i,
  input  logic        rst_ni,
  sgdlr_in_if.sink    in_s,
  sgdlr_out_if.source out_m,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  sgdlr_pkg::cfg_t  cfg_q;
  sgdlr_pkg::item_t item;
  logic item_valid, item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size     <= 16'd66;
      cfg_q.feature_count <= 5'd11;
      cfg_q.learn_enable  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgdlr_pkg::CfgLearnRate: cfg_q.step_size     <= cfg_data_i;
        sgdlr_pkg::CfgFeatCount: cfg_q.feature_count <= cfg_data_i[4:0];
        sgdlr_pkg::CfgLearnEn:   cfg_q.learn_enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sgdlr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_s         (in_s),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  sgdlr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_m        (out_m)
  );

endmodule

// ----- rtl/sgdlr_front.sv -----
// Front end: accepts input beats, decodes the opcode and queues items.
// Depends on sgdlr_pkg and sgdlr_if.
`timescale 1ns / 1ps
module sgdlr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  sgdlr_in_if.sink           in_s,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output sgdlr_pkg::item_t   item_o
);

  localparam int PW = (sgdlr_pkg::QDepth > 1) ? $clog2(sgdlr_pkg::QDepth) : 1;
  localparam int CW = $clog2(sgdlr_pkg::QDepth + 1);

  sgdlr_pkg::item_t mem_q [sgdlr_pkg::QDepth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic push, pop;
  sgdlr_pkg::item_t in_item;

  assign in_s.ready   = (cnt_q != CW'(sgdlr_pkg::QDepth));
  assign push         = in_s.valid && in_s.ready;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    in_item.op    = sgdlr_pkg::op_e'(in_s.opcode);
    in_item.value = in_s.sample_value;
    in_item.index = in_s.weight_index;
    wr_d  = push ? ((wr_q == PW'(sgdlr_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == PW'(sgdlr_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(sgdlr_pkg::QDepth)) else $error("queue overfilled");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("push lost");
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1)) else $error("pop lost");

endmodule

// ----- rtl/sgdlr_back.sv -----
// Back end: feature buffer, weights, sums and the multiply sequencer.
// Depends on sgdlr_pkg and sgdlr_if.
`timescale 1ns / 1ps
module sgdlr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgdlr_pkg::cfg_t    cfg_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  sgdlr_pkg::item_t   item_i,
  sgdlr_out_if.source        out_m
);

  localparam int KW = sgdlr_pkg::KW;
  localparam int BW = sgdlr_pkg::BW;
  localparam int FB = sgdlr_pkg::FracBits;
  localparam int MF = sgdlr_pkg::MaxFeatures;

  typedef enum logic [3:0] {
    S_IDLE, S_DOT_MUL, S_DOT_ACC, S_PRED, S_RES, S_SQ_MUL, S_SQ_ADD,
    S_ELR_MUL, S_BIAS, S_UPD_MUL, S_UPD_ADD, S_EMIT
  } state_e;

  state_e state_q;
  logic signed [31:0] w_q [MF+1];
  logic signed [23:0] buf_q [MF];
  logic [KW-1:0] fill_q, k_q, n;
  logic [47:0] sum_q;
  logic [31:0] count_q;
  logic signed [63:0] acc_q, prod_q;
  logic signed [23:0] val_q;
  logic signed [31:0] pred_q, res_q, wval_q;
  logic signed [32:0] elr_q;
  logic sat_q, tgt_q;
  logic out_valid_q;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [23:0] xk;
  logic [KW-1:0] k_inc;
  logic out_free;
  sgdlr_pkg::sat_t s_pred, s_res, s_bias, s_upd;
  logic signed [63:0] rnd_acc, rnd_elr, rnd_step, w0_wide;
  logic [62:0] term;
  logic [48:0] sum_add;
  logic [31:0] mag;
  logic sum_sat;

  assign n        = (cfg_i.feature_count > 5'(MF)) ? KW'(MF) : KW'(cfg_i.feature_count);
  assign k_inc    = k_q + 1'b1;
  assign xk       = (k_q < fill_q) ? buf_q[k_q[BW-1:0]] : '0;
  assign out_free = !out_valid_q || out_m.ready;
  assign item_ready_o = (state_q == S_IDLE);
  assign mag      = res_q[31] ? 32'(-res_q) : res_q;

  always_comb begin
    case (state_q)
      S_DOT_MUL: begin
        mul_a = 34'(w_q[k_inc]);
        mul_b = 34'(xk);
      end
      S_SQ_MUL: begin
        mul_a = {2'b00, mag};
        mul_b = {2'b00, mag};
      end
      S_ELR_MUL: begin
        mul_a = {18'd0, cfg_i.step_size};
        mul_b = 34'(res_q);
      end
      S_UPD_MUL: begin
        mul_a = 34'(elr_q);
        mul_b = 34'(xk);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod     = mul_a * mul_b;
    rnd_acc  = (acc_q + (64'sd1 <<< (FB - 1))) >>> FB;
    s_pred   = sgdlr_pkg::sat32(rnd_acc);
    s_res    = sgdlr_pkg::sat32(64'(pred_q) - 64'(val_q));
    term     = (prod_q[62:0] + (63'd1 << (FB - 1))) >> FB;
    sum_add  = {1'b0, sum_q} + term[48:0];
    sum_sat  = (term[62:48] != '0) || sum_add[48];
    rnd_elr  = (prod_q + (64'sd1 <<< (sgdlr_pkg::LrFrac - 1))) >>> sgdlr_pkg::LrFrac;
    s_bias   = sgdlr_pkg::sat32(64'(w_q[0]) - rnd_elr);
    rnd_step = (prod_q + (64'sd1 <<< (FB - 1))) >>> FB;
    s_upd    = sgdlr_pkg::sat32(64'(w_q[k_inc]) - rnd_step);
    w0_wide  = 64'(w_q[0]) <<< FB;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      k_q         <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      tgt_q       <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      prod_q      <= '0;
      val_q       <= '0;
      pred_q      <= '0;
      res_q       <= '0;
      wval_q      <= '0;
      elr_q       <= '0;
      out_m.prediction        <= '0;
      out_m.residual          <= '0;
      out_m.squared_error_sum <= '0;
      out_m.sample_count      <= '0;
      out_m.weight_value      <= '0;
      out_m.saturated         <= 1'b0;
      for (int i = 0; i <= MF; i++) w_q[i] <= '0;
      for (int i = 0; i < MF; i++) buf_q[i] <= '0;
    end else begin
      if (state_q == S_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_m.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          k_q <= '0;
          if (item_valid_i) begin
            case (item_i.op)
              sgdlr_pkg::OpFeature: begin
                if (fill_q < n) begin
                  buf_q[fill_q[BW-1:0]] <= item_i.value;
                  fill_q <= fill_q + 1'b1;
                end
              end
              sgdlr_pkg::OpClear: begin
                for (int i = 0; i <= MF; i++) w_q[i] <= '0;
                sum_q   <= '0;
                count_q <= '0;
                fill_q  <= '0;
              end
              sgdlr_pkg::OpRead: begin
                pred_q  <= '0;
                res_q   <= '0;
                sat_q   <= 1'b0;
                tgt_q   <= 1'b0;
                wval_q  <= (item_i.index <= 5'(MF)) ? w_q[item_i.index[KW-1:0]] : '0;
                state_q <= S_EMIT;
              end
              default: begin
                val_q   <= item_i.value;
                acc_q   <= w0_wide;
                sat_q   <= 1'b0;
                tgt_q   <= 1'b1;
                wval_q  <= '0;
                state_q <= (n == '0) ? S_PRED : S_DOT_MUL;
              end
            endcase
          end
        end
        S_DOT_MUL: begin
          prod_q  <= prod[63:0];
          state_q <= S_DOT_ACC;
        end
        S_DOT_ACC: begin
          acc_q   <= acc_q + prod_q;
          k_q     <= k_inc;
          state_q <= (k_inc == n) ? S_PRED : S_DOT_MUL;
        end
        S_PRED: begin
          pred_q  <= s_pred.val;
          sat_q   <= sat_q | s_pred.sat;
          state_q <= S_RES;
        end
        S_RES: begin
          res_q   <= s_res.val;
          sat_q   <= sat_q | s_res.sat;
          state_q <= S_SQ_MUL;
        end
        S_SQ_MUL: begin
          prod_q  <= prod[63:0];
          state_q <= S_SQ_ADD;
        end
        S_SQ_ADD: begin
          sum_q <= sum_sat ? '1 : sum_add[47:0];
          if (count_q != '1) count_q <= count_q + 1'b1;
          sat_q   <= sat_q | sum_sat | (count_q == '1);
          state_q <= cfg_i.learn_enable ? S_ELR_MUL : S_EMIT;
        end
        S_ELR_MUL: begin
          prod_q  <= prod[63:0];
          state_q <= S_BIAS;
        end
        S_BIAS: begin
          elr_q   <= rnd_elr[32:0];
          w_q[0]  <= s_bias.val;
          sat_q   <= sat_q | s_bias.sat;
          k_q     <= '0;
          state_q <= (n == '0) ? S_EMIT : S_UPD_MUL;
        end
        S_UPD_MUL: begin
          prod_q  <= prod[63:0];
          state_q <= S_UPD_ADD;
        end
        S_UPD_ADD: begin
          w_q[k_inc] <= s_upd.val;
          sat_q      <= sat_q | s_upd.sat;
          k_q        <= k_inc;
          state_q    <= (k_inc == n) ? S_EMIT : S_UPD_MUL;
        end
        S_EMIT: begin
          if (out_free) begin
            out_m.prediction        <= pred_q;
            out_m.residual          <= res_q;
            out_m.squared_error_sum <= sum_q;
            out_m.sample_count      <= count_q;
            out_m.weight_value      <= wval_q;
            out_m.saturated         <= sat_q;
            if (tgt_q) fill_q <= '0;
            k_q     <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_m.valid = out_valid_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= KW'(MF)) else $error("fill past buffer");
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DOT_MUL || state_q == S_UPD_MUL) |-> (k_q < n)) else $error("k out of range");
  a_idle_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (k_q == '0)) else $error("k not reset");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench of the SGD linear regression learner: directed table and sequences, then random beats.
// Carries its own predictor of weights, sums and feature buffer; depends on sgdlr_pkg, sgdlr_if and the learner.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic signed [31:0] prediction;
    logic signed [31:0] residual;
    logic [47:0]        squared_error_sum;
    logic [31:0]        sample_count;
    logic signed [31:0] weight_value;
    logic               saturated;
  } learner_res_t;

  typedef struct {
    sgdlr_pkg::op_e     op;
    logic signed [23:0] value;
    logic [4:0]         index;
    bit                 has_fixed;
    learner_res_t       fixed;
  } stim_row_t;

  localparam longint SumMax = 64'hFFFF_FFFF_FFFF;
  localparam int CycleLimit = 4_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  sgdlr_in_if  in_s ();
  sgdlr_out_if out_m ();

  sgd_linear_regression_learner u_dut (
    .clk_i, .rst_ni, .in_s(in_s.sink), .out_m(out_m.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0]        lr_q;
  logic [4:0]         fcount_q;
  logic               learn_q;
  logic signed [31:0] wt [sgdlr_pkg::MaxFeatures+1];
  logic signed [23:0] fbuf [sgdlr_pkg::MaxFeatures];
  int unsigned        fill_q;
  longint unsigned    err_sum_q;
  logic [31:0]        seen_q;

  learner_res_t expected_q [$];
  learner_res_t fixed_q [$];
  bit           fixed_valid_q [$];
  int  errors = 0;
  longint cycles = 0;
  bit  quiet_in = 0, quiet_out = 0;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic predict_learner(input sgdlr_pkg::op_e op, input logic signed [23:0] val,
                                 input logic [4:0] idx);
    int unsigned n;
    longint x [sgdlr_pkg::MaxFeatures];
    longint acc, pred, res, elr, stp;
    longint unsigned mag, term;
    bit sat;
    learner_res_t r;
    n = (fcount_q > sgdlr_pkg::MaxFeatures) ? sgdlr_pkg::MaxFeatures : fcount_q;
    sat = 0;
    r = '0;
    case (op)
      sgdlr_pkg::OpFeature: begin
        if (fill_q < n) begin
          fbuf[fill_q] = val;
          fill_q++;
        end
      end
      sgdlr_pkg::OpClear: begin
        foreach (wt[k]) wt[k] = '0;
        err_sum_q = 0;
        seen_q = '0;
        fill_q = 0;
      end
      sgdlr_pkg::OpRead: begin
        r.squared_error_sum = err_sum_q[47:0];
        r.sample_count = seen_q;
        r.weight_value = (idx <= sgdlr_pkg::MaxFeatures) ? wt[idx] : '0;
        expected_q.insert(expected_q.size(), r);
      end
      default: begin
        for (int k = 0; k < sgdlr_pkg::MaxFeatures; k++)
          x[k] = (k < n && k < fill_q) ? longint'(fbuf[k]) : 0;
        acc = longint'(wt[0]) * (longint'(1) <<< sgdlr_pkg::FracBits);
        for (int k = 0; k < n; k++) acc += longint'(wt[k+1]) * x[k];
        pred = clamp32(round_shift(acc, sgdlr_pkg::FracBits), sat);
        res = clamp32(pred - longint'(val), sat);
        mag = (res < 0) ? -res : res;
        term = (mag * mag + (64'd1 << (sgdlr_pkg::FracBits - 1))) >> sgdlr_pkg::FracBits;
        if (term > SumMax - err_sum_q) begin
          err_sum_q = SumMax;
          sat = 1;
        end else err_sum_q += term;
        if (seen_q == 32'hFFFF_FFFF) sat = 1;
        else seen_q++;
        if (learn_q) begin
          elr = round_shift(longint'({1'b0, lr_q}) * res, sgdlr_pkg::LrFrac);
          wt[0] = clamp32(longint'(wt[0]) - elr, sat);
          for (int k = 0; k < n; k++) begin
            stp = round_shift(elr * x[k], sgdlr_pkg::FracBits);
            wt[k+1] = clamp32(longint'(wt[k+1]) - stp, sat);
          end
        end
        fill_q = 0;
        r.prediction = pred[31:0];
        r.residual = res[31:0];
        r.squared_error_sum = err_sum_q[47:0];
        r.sample_count = seen_q;
        r.saturated = sat;
        expected_q.insert(expected_q.size(), r);
      end
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sgdlr_pkg::CfgLearnRate: lr_q = data;
      sgdlr_pkg::CfgFeatCount: fcount_q = data[4:0];
      sgdlr_pkg::CfgLearnEn:   learn_q = data[0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    in_s.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // hold input beat until accepted
  task automatic send_beat(input sgdlr_pkg::op_e op, input logic signed [23:0] val,
                           input logic [4:0] idx, input bit has_fixed,
                           input learner_res_t fixed);
    while (!quiet_in && $urandom_range(99) < 9) begin
      in_s.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_s.valid <= 1'b1;
    in_s.opcode <= op;
    in_s.sample_value <= val;
    in_s.weight_index <= idx;
    do @(posedge clk_i); while (!in_s.ready);
    predict_learner(op, val, idx);
    if (op == sgdlr_pkg::OpTarget || op == sgdlr_pkg::OpRead) begin
      fixed_q.insert(fixed_q.size(), fixed);
      fixed_valid_q.insert(fixed_valid_q.size(), has_fixed);
    end
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count, input int maxfeat);
    int nf;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) begin
        nf = $urandom_range(maxfeat);
        for (int k = 0; k < nf; k++)
          send_beat(sgdlr_pkg::OpFeature,
                    24'($urandom_range(255) < 8 ? $urandom : $urandom >> 10),
                    '0, 0, '0);
        send_beat(sgdlr_pkg::OpTarget, 24'($urandom), 5'($urandom), 0, '0);
        i += nf;
      end else begin
        case ($urandom_range(9))
          0:       send_beat(sgdlr_pkg::OpClear, 24'($urandom), 5'($urandom), 0, '0);
          1, 2, 3: send_beat(sgdlr_pkg::OpRead, 24'($urandom), 5'($urandom), 0, '0);
          default: send_beat(sgdlr_pkg::OpFeature, 24'($urandom), 5'($urandom), 0, '0);
        endcase
      end
    end
  endtask

  // sink side: random stall, compare at rising edge
  always @(negedge clk_i) begin
    out_m.ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    learner_res_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sgd_linear_regression_learner verification failed");
      $finish;
    end
    if (rst_ni && out_m.valid && out_m.ready) begin
      got = {out_m.prediction, out_m.residual, out_m.squared_error_sum,
             out_m.sample_count, out_m.weight_value, out_m.saturated};
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (fixed_valid_q.pop_front() && fixed_q[0] != want) begin
          $error("table row disagrees with predictor");
          errors++;
        end
        void'(fixed_q.pop_front());
        if (got.prediction !== want.prediction) begin
          $error("prediction exp %0d got %0d", want.prediction, got.prediction); errors++;
        end
        if (got.residual !== want.residual) begin
          $error("residual exp %0d got %0d", want.residual, got.residual); errors++;
        end
        if (got.squared_error_sum !== want.squared_error_sum) begin
          $error("squared_error_sum exp %0d got %0d", want.squared_error_sum,
                 got.squared_error_sum); errors++;
        end
        if (got.sample_count !== want.sample_count) begin
          $error("sample_count exp %0d got %0d", want.sample_count, got.sample_count);
          errors++;
        end
        if (got.weight_value !== want.weight_value) begin
          $error("weight_value exp %0d got %0d", want.weight_value, got.weight_value);
          errors++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated exp %0d got %0d", want.saturated, got.saturated); errors++;
        end
      end
    end
  end

  function automatic stim_row_t row(sgdlr_pkg::op_e op, logic signed [23:0] v,
                                    logic [4:0] idx, bit hf = 0, learner_res_t f = '0);
    stim_row_t s;
    s.op = op; s.value = v; s.index = idx; s.has_fixed = hf; s.fixed = f;
    return s;
  endfunction

  stim_row_t directed [$];

  task automatic add_row(input stim_row_t s);
    directed.insert(directed.size(), s);
  endtask

  initial begin
    in_s.valid = 1'b0;
    in_s.opcode = '0;
    in_s.sample_value = '0;
    in_s.weight_index = '0;
    out_m.ready = 1'b0;
    lr_q = 16'd66; fcount_q = 5'd11; learn_q = 1'b1;
    foreach (wt[k]) wt[k] = '0;
    foreach (fbuf[k]) fbuf[k] = '0;
    fill_q = 0; err_sum_q = 0; seen_q = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    add_row(row(sgdlr_pkg::OpRead, 24'sd0, 5'd0, 1, '0));
    add_row(row(sgdlr_pkg::OpRead, 24'sd0, 5'd16, 1, '0));
    add_row(row(sgdlr_pkg::OpRead, 24'sd0, 5'd31, 1, '0));
    add_row(row(sgdlr_pkg::OpTarget, 24'sd0, 5'd0, 1,
                '{32'sd0, 32'sd0, 48'd0, 32'd1, 32'sd0, 1'b0}));
    add_row(row(sgdlr_pkg::OpFeature, 24'h7FFFFF, 5'd0));
    add_row(row(sgdlr_pkg::OpFeature, 24'h800000, 5'd31));
    add_row(row(sgdlr_pkg::OpTarget, 24'h800000, 5'd0));
    add_row(row(sgdlr_pkg::OpTarget, 24'h7FFFFF, 5'd0));
    for (int k = 0; k < 13; k++) add_row(row(sgdlr_pkg::OpFeature, 24'h7FFFFF, 5'd0));
    add_row(row(sgdlr_pkg::OpTarget, 24'h800000, 5'd0));
    add_row(row(sgdlr_pkg::OpRead, 24'sd0, 5'd1));
    add_row(row(sgdlr_pkg::OpRead, 24'sd0, 5'd11));
    add_row(row(sgdlr_pkg::OpClear, 24'sd0, 5'd0));
    add_row(row(sgdlr_pkg::OpRead, 24'sd0, 5'd0, 1, '0));
    foreach (directed[i])
      send_beat(directed[i].op, directed[i].value, directed[i].index,
                directed[i].has_fixed, directed[i].fixed);
    drain_and_settle();

    // extremes and saturation: max rate, all features
    write_reg(sgdlr_pkg::CfgLearnRate, 16'hFFFF);
    write_reg(sgdlr_pkg::CfgFeatCount, 5'd31);
    for (int k = 0; k < 8; k++) send_beat(sgdlr_pkg::OpFeature, 24'h7FFFFF, '0, 0, '0);
    for (int k = 0; k < 6; k++) send_beat(sgdlr_pkg::OpTarget, 24'h800000, '0, 0, '0);
    for (int k = 0; k < 16; k++) send_beat(sgdlr_pkg::OpFeature, 24'h7FFFFF, '0, 0, '0);
    for (int k = 0; k < 4; k++) send_beat(sgdlr_pkg::OpTarget, 24'h7FFFFF, '0, 0, '0);
    send_beat(sgdlr_pkg::OpRead, '0, 5'd16, 0, '0);
    drain_and_settle();

    write_reg(sgdlr_pkg::CfgFeatCount, 5'd0);
    write_reg(sgdlr_pkg::CfgLearnEn, 16'd0);
    write_reg(sgdlr_pkg::CfgLearnRate, 16'd0);
    send_beat(sgdlr_pkg::OpFeature, 24'sd5, '0, 0, '0);
    send_beat(sgdlr_pkg::OpTarget, 24'sd77, '0, 0, '0);
    send_random(60, 3);
    drain_and_settle();

    quiet_in = 1; quiet_out = 1;
    write_reg(sgdlr_pkg::CfgLearnEn, 16'd1);
    write_reg(sgdlr_pkg::CfgLearnRate, 16'd2000);
    write_reg(sgdlr_pkg::CfgFeatCount, 5'd4);
    send_random(300, 6);
    drain_and_settle();
    quiet_in = 0; quiet_out = 0;

    write_reg(sgdlr_pkg::CfgLearnRate, 16'($urandom));
    write_reg(sgdlr_pkg::CfgFeatCount, 5'd16);
    send_random(300, 18);
    drain_and_settle();

    write_reg(sgdlr_pkg::CfgLearnRate, 16'd66);
    write_reg(sgdlr_pkg::CfgFeatCount, 5'd1);
    send_random(300, 2);
    drain_and_settle();

    write_reg(sgdlr_pkg::CfgFeatCount, 5'($urandom_range(1, 16)));
    write_reg(sgdlr_pkg::CfgLearnEn, 16'($urandom_range(1)));
    send_random(300, 17);
    drain_and_settle();

    if (errors == 0 && expected_q.size() == 0) begin
      $display("sgd_linear_regression_learner verification clean");
    end else begin
      $display("sgd_linear_regression_learner verification failed");
    end
    $finish;
  end

endmodule
